// ===== hdl/cmis_pkg.sv =====
// shared types, character codes and the microcode store of the card machine
package cmis_pkg;

    localparam int ADDR_W = 7;
    localparam int WORD_W = 32;
    localparam int UPC_W  = 6;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [UPC_W-1:0]  t_upc;

    localparam t_word SPACES = 32'h2020_2020;

    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;

    typedef enum logic [2:0] {
        ST_OK, ST_HALTED, ST_AWAIT, ST_BAD_ADDR, ST_OVERRUN, ST_UNEXPECTED, ST_PRINT
    } t_status;

    // step precheck outcome, in the order of the dispatch words
    typedef enum logic [1:0] {SC_HALT, SC_PEND, SC_OVR, SC_GO} t_scode;

    // instruction class, in the order of the dispatch words
    typedef enum logic [3:0] {
        CL_H, CL_UNK, CL_BAD, CL_OVR, CL_GD, CL_PD, CL_LR, CL_SR, CL_CR, CL_BT
    } t_cls;

    typedef enum logic [1:0] {J_NEXT, J_IF, J_MAP} t_jmp;
    typedef enum logic [2:0] {C_LP_FULL, C_NOT_PEND, C_RA_DONE, C_RA_END1, C_IN_LAST} t_cond;
    typedef enum logic [1:0] {M_OP, M_STEP, M_CLASS} t_map;
    typedef enum logic [1:0] {A_IC, A_ADDR, A_RA, A_LP} t_asel;
    typedef enum logic [1:0] {WD_IN, WD_ACC, WD_SPACE} t_wsrc;

    typedef enum logic [3:0] {
        D_NONE, D_CLEAR, D_LP_INC, D_IC_INC, D_IR_LOAD, D_HALT, D_GD, D_SPAN,
        D_ACC_LOAD, D_CMP, D_BRANCH, D_RA_INC, D_PEND_CLR
    } t_dop;

    typedef struct packed {
        logic    wait_in;
        t_jmp    jmp;
        t_cond   cnd;
        t_map    mp;
        t_upc    tgt;
        t_upc    nxt;
        logic    rd;
        logic    we;
        logic    mclr;
        t_asel   asel;
        t_wsrc   wsrc;
        t_dop    dop;
        logic    emit;
        t_status st;
        logic    osel;
        logic    lsel;
    } t_cw;

    typedef struct packed {
        logic   lp_full;
        logic   not_pend;
        logic   ra_done;
        logic   ra_end1;
        logic   in_last;
        t_scode scode;
        t_cls   cls;
    } t_flags;

    typedef struct packed {
        logic  we;
        logic  rd;
        logic  clr;
        t_addr addr;
        t_word wdata;
    } t_mreq;

    // microcode addresses
    localparam t_upc UA_IDLE    = 6'd0;
    localparam t_upc UA_CLR     = 6'd1;
    localparam t_upc UA_LOAD0   = 6'd2;
    localparam t_upc UA_STEP0   = 6'd3;
    localparam t_upc UA_DATA0   = 6'd4;
    localparam t_upc UA_E_HALT  = 6'd5;
    localparam t_upc UA_E_AWAIT = 6'd6;
    localparam t_upc UA_E_OVR   = 6'd7;
    localparam t_upc UA_FETCH   = 6'd8;
    localparam t_upc UA_LOAD1   = 6'd9;
    localparam t_upc UA_DEC     = 6'd10;
    localparam t_upc UA_CLS     = 6'd11;
    localparam t_upc UA_H       = 6'd12;
    localparam t_upc UA_E_OK    = 6'd13;
    localparam t_upc UA_E_BAD   = 6'd14;
    localparam t_upc UA_E_OVR2  = 6'd15;
    localparam t_upc UA_GD      = 6'd16;
    localparam t_upc UA_PD0     = 6'd17;
    localparam t_upc UA_LR0     = 6'd18;
    localparam t_upc UA_SR      = 6'd19;
    localparam t_upc UA_CR0     = 6'd20;
    localparam t_upc UA_BT      = 6'd21;
    localparam t_upc UA_LR1     = 6'd22;
    localparam t_upc UA_CR1     = 6'd23;
    localparam t_upc UA_PD1     = 6'd24;
    localparam t_upc UA_PD2     = 6'd25;
    localparam t_upc UA_E_UNEXP = 6'd26;
    localparam t_upc UA_DW0     = 6'd27;
    localparam t_upc UA_DW1     = 6'd28;
    localparam t_upc UA_DL      = 6'd29;
    localparam t_upc UA_DF0     = 6'd30;
    localparam t_upc UA_DF1     = 6'd31;
    localparam t_upc UA_DEND    = 6'd32;

    localparam t_cw CW_NOP = '{
        wait_in: 1'b0, jmp: J_NEXT, cnd: C_LP_FULL, mp: M_OP, tgt: UA_IDLE, nxt: UA_IDLE,
        rd: 1'b0, we: 1'b0, mclr: 1'b0, asel: A_IC, wsrc: WD_IN, dop: D_NONE,
        emit: 1'b0, st: ST_OK, osel: 1'b0, lsel: 1'b0
    };

    function automatic t_cw ucode(input t_upc a);
        t_cw w;
        w = CW_NOP;
        unique case (a)
            UA_IDLE: begin
                w.wait_in = 1'b1;
                w.jmp     = J_MAP;
                w.mp      = M_OP;
                w.tgt     = UA_CLR;
            end
            UA_CLR: begin
                w.mclr = 1'b1;
                w.dop  = D_CLEAR;
                w.emit = 1'b1;
            end
            UA_LOAD0: begin
                w.jmp = J_IF;
                w.cnd = C_LP_FULL;
                w.tgt = UA_E_OVR;
                w.nxt = UA_LOAD1;
            end
            UA_STEP0: begin
                w.jmp = J_MAP;
                w.mp  = M_STEP;
                w.tgt = UA_E_HALT;
            end
            UA_DATA0: begin
                w.jmp = J_IF;
                w.cnd = C_NOT_PEND;
                w.tgt = UA_E_UNEXP;
                w.nxt = UA_DW0;
            end
            UA_E_HALT: begin
                w.emit = 1'b1;
                w.st   = ST_HALTED;
            end
            UA_E_AWAIT: begin
                w.emit = 1'b1;
                w.st   = ST_AWAIT;
            end
            UA_E_OVR: begin
                w.emit = 1'b1;
                w.st   = ST_OVERRUN;
            end
            UA_FETCH: begin
                w.rd   = 1'b1;
                w.asel = A_IC;
                w.dop  = D_IC_INC;
                w.nxt  = UA_DEC;
            end
            UA_LOAD1: begin
                w.we   = 1'b1;
                w.asel = A_LP;
                w.wsrc = WD_IN;
                w.dop  = D_LP_INC;
                w.emit = 1'b1;
            end
            UA_DEC: begin
                w.dop = D_IR_LOAD;
                w.nxt = UA_CLS;
            end
            UA_CLS: begin
                w.jmp = J_MAP;
                w.mp  = M_CLASS;
                w.tgt = UA_H;
            end
            UA_H: begin
                w.dop  = D_HALT;
                w.emit = 1'b1;
                w.st   = ST_HALTED;
            end
            UA_E_OK: begin
                w.emit = 1'b1;
            end
            UA_E_BAD: begin
                w.emit = 1'b1;
                w.st   = ST_BAD_ADDR;
            end
            UA_E_OVR2: begin
                w.emit = 1'b1;
                w.st   = ST_OVERRUN;
            end
            UA_GD: begin
                w.dop  = D_GD;
                w.emit = 1'b1;
                w.st   = ST_AWAIT;
            end
            UA_PD0: begin
                w.dop = D_SPAN;
                w.nxt = UA_PD1;
            end
            UA_LR0: begin
                w.rd   = 1'b1;
                w.asel = A_ADDR;
                w.nxt  = UA_LR1;
            end
            UA_SR: begin
                w.we   = 1'b1;
                w.asel = A_ADDR;
                w.wsrc = WD_ACC;
                w.emit = 1'b1;
            end
            UA_CR0: begin
                w.rd   = 1'b1;
                w.asel = A_ADDR;
                w.nxt  = UA_CR1;
            end
            UA_BT: begin
                w.dop  = D_BRANCH;
                w.emit = 1'b1;
            end
            UA_LR1: begin
                w.dop  = D_ACC_LOAD;
                w.emit = 1'b1;
            end
            UA_CR1: begin
                w.dop  = D_CMP;
                w.emit = 1'b1;
            end
            UA_PD1: begin
                w.rd   = 1'b1;
                w.asel = A_RA;
                w.dop  = D_RA_INC;
                w.nxt  = UA_PD2;
            end
            UA_PD2: begin
                w.emit = 1'b1;
                w.st   = ST_PRINT;
                w.osel = 1'b1;
                w.lsel = 1'b1;
                w.jmp  = J_IF;
                w.cnd  = C_RA_DONE;
                w.tgt  = UA_IDLE;
                w.nxt  = UA_PD1;
            end
            UA_E_UNEXP: begin
                w.emit = 1'b1;
                w.st   = ST_UNEXPECTED;
            end
            UA_DW0: begin
                w.jmp = J_IF;
                w.cnd = C_RA_DONE;
                w.tgt = UA_DL;
                w.nxt = UA_DW1;
            end
            UA_DW1: begin
                w.we   = 1'b1;
                w.asel = A_RA;
                w.wsrc = WD_IN;
                w.dop  = D_RA_INC;
                w.nxt  = UA_DL;
            end
            UA_DL: begin
                w.jmp = J_IF;
                w.cnd = C_IN_LAST;
                w.tgt = UA_DF0;
                w.nxt = UA_E_AWAIT;
            end
            UA_DF0: begin
                w.jmp = J_IF;
                w.cnd = C_RA_DONE;
                w.tgt = UA_DEND;
                w.nxt = UA_DF1;
            end
            UA_DF1: begin
                w.we   = 1'b1;
                w.asel = A_RA;
                w.wsrc = WD_SPACE;
                w.dop  = D_RA_INC;
                w.jmp  = J_IF;
                w.cnd  = C_RA_END1;
                w.tgt  = UA_DEND;
                w.nxt  = UA_DF1;
            end
            UA_DEND: begin
                w.dop  = D_PEND_CLR;
                w.emit = 1'b1;
            end
            default: begin
                w = CW_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/card_machine_instruction_step.sv =====
// Card machine instruction step: emulates a MEM_WORDS-word machine with four-character
// words, driven by one item per transfer (clear, load, step, data). A microprogram walks
// each item through a single-port word memory, one control word per clock while the
// sequencer is not held, so the cost of an item is set by how many memory accesses and
// decisions it needs: a step is refused at once when halted, awaiting data or with the
// counter past memory, PD emits one result per printed word, a data word with no read
// pending is refused, and the last data word of a card pads the rest of the span with
// spaces. Clear is immediate (per-word valid bits, no sweep). One item is worked on at a
// time; the next is taken while the last result still sits in the output register,
// and the sequencer holds when a new result finds that register occupied and stalled.
module card_machine_instruction_step #(
    parameter int MEM_WORDS = 100,
    parameter int IO_WORDS  = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_data_word,
    input  logic        i_last_of_card,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_out_word,
    output logic        o_last,
    output logic [6:0]  o_instr_count,
    output logic        o_cond_flag
);
    import cmis_pkg::*;

    t_cw     cw;
    t_flags  flags;
    t_mreq   mreq;
    t_word   rdata;
    t_status status;
    logic    fire;
    logic    out_free;

    cmis_mem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_rdata (rdata)
    );

    cmis_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_out_free (out_free),
        .i_flags    (flags),
        .o_cw       (cw),
        .o_fire     (fire),
        .o_in_stall (o_in_stall)
    );

    cmis_dp #(
        .MEM_WORDS (MEM_WORDS),
        .IO_WORDS  (IO_WORDS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cw           (cw),
        .i_fire         (fire),
        .i_data_word    (i_data_word),
        .i_last_of_card (i_last_of_card),
        .i_rdata        (rdata),
        .i_out_stall    (i_out_stall),
        .o_flags        (flags),
        .o_mreq         (mreq),
        .o_out_free     (out_free),
        .o_out_valid    (o_out_valid),
        .o_status       (status),
        .o_out_word     (o_out_word),
        .o_last         (o_last),
        .o_instr_count  (o_instr_count),
        .o_cond_flag    (o_cond_flag)
    );

    assign o_status = status;

endmodule

// ===== hdl/cmis_mem.sv =====
// word memory with per-word valid bits, unwritten words read as spaces
module cmis_mem #(
    parameter int MEM_WORDS = 100
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cmis_pkg::t_mreq i_req,
    output cmis_pkg::t_word o_rdata
);
    import cmis_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);

    t_word              r_mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] r_valid;
    t_word              r_rdata;
    logic               r_rvalid;
    logic [AW-1:0]      idx;

    assign idx = i_req.addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[idx] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rdata  <= r_mem[idx];
            r_rvalid <= r_valid[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[idx] <= 1'b1;
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : SPACES;

endmodule

// ===== hdl/cmis_seq.sv =====
// microprogram counter, control store lookup and jump logic
module cmis_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_op,
    input  logic             i_out_free,
    input  cmis_pkg::t_flags i_flags,
    output cmis_pkg::t_cw    o_cw,
    output logic             o_fire,
    output logic             o_in_stall
);
    import cmis_pkg::*;

    t_upc       r_upc;
    t_upc       n_upc;
    t_cw        cw;
    logic       cond;
    logic [3:0] mv;

    assign cw = ucode(r_upc);

    // a word with a transfer or a result waits for its handshake partner
    assign o_fire     = (!cw.wait_in || i_in_valid) && (!cw.emit || i_out_free);
    assign o_in_stall = !cw.wait_in || !i_rst_n;
    assign o_cw       = cw;

    always_comb begin
        unique case (cw.cnd)
            C_LP_FULL:  cond = i_flags.lp_full;
            C_NOT_PEND: cond = i_flags.not_pend;
            C_RA_DONE:  cond = i_flags.ra_done;
            C_RA_END1:  cond = i_flags.ra_end1;
            C_IN_LAST:  cond = i_flags.in_last;
            default:    cond = 1'b0;
        endcase
    end

    always_comb begin
        unique case (cw.mp)
            M_OP:    mv = {2'b00, i_op};
            M_STEP:  mv = {2'b00, i_flags.scode};
            M_CLASS: mv = i_flags.cls;
            default: mv = '0;
        endcase
    end

    always_comb begin
        n_upc = r_upc;
        if (o_fire) begin
            unique case (cw.jmp)
                J_NEXT:  n_upc = cw.nxt;
                J_IF:    n_upc = cond ? cw.tgt : cw.nxt;
                J_MAP:   n_upc = cw.tgt + t_upc'(mv);
                default: n_upc = UA_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ===== hdl/cmis_dp.sv =====
// machine registers, instruction decode, memory request and result register
module cmis_dp #(
    parameter int MEM_WORDS = 100,
    parameter int IO_WORDS  = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cmis_pkg::t_cw     i_cw,
    input  logic              i_fire,
    input  logic [31:0]       i_data_word,
    input  logic              i_last_of_card,
    input  cmis_pkg::t_word   i_rdata,
    input  logic              i_out_stall,
    output cmis_pkg::t_flags  o_flags,
    output cmis_pkg::t_mreq   o_mreq,
    output logic              o_out_free,
    output logic              o_out_valid,
    output cmis_pkg::t_status o_status,
    output logic [31:0]       o_out_word,
    output logic              o_last,
    output logic [6:0]        o_instr_count,
    output logic              o_cond_flag
);
    import cmis_pkg::*;

    localparam t_addr MEM_END = t_addr'(MEM_WORDS);
    localparam t_addr IO_SPAN = t_addr'(IO_WORDS);

    t_word   r_acc, n_acc;
    logic    r_flag, n_flag;
    t_addr   r_ic, n_ic;
    t_addr   r_lp, n_lp;
    logic    r_halt, n_halt;
    logic    r_pend, n_pend;
    t_addr   r_ra, n_ra;
    t_addr   r_re, n_re;
    t_word   r_ir;
    t_word   r_word;
    logic    r_lastc;
    logic    r_ov;
    t_status r_ost;
    t_word   r_oword;
    logic    r_olast;
    t_addr   r_oic;
    logic    r_oflag;

    logic [7:0] c0, c1, d2, d3;
    logic       known, digits;
    t_addr      addr, span_sum, span_end;
    logic       accept;

    assign accept = i_fire && i_cw.wait_in;

    // instruction fields
    assign c0 = r_ir[31:24];
    assign c1 = r_ir[23:16];
    assign d2 = r_ir[15:8];
    assign d3 = r_ir[7:0];

    assign known = (c0 == CH_G && c1 == CH_D) || (c0 == CH_P && c1 == CH_D) ||
                   (c0 == CH_L && c1 == CH_R) || (c0 == CH_S && c1 == CH_R) ||
                   (c0 == CH_C && c1 == CH_R) || (c0 == CH_B && c1 == CH_T);
    assign digits = (d2 >= CH_0) && (d2 <= CH_9) && (d3 >= CH_0) && (d3 <= CH_9);
    assign addr   = t_addr'(d2[3:0]) * t_addr'(10) + t_addr'(d3[3:0]);

    assign span_sum = addr + IO_SPAN;
    assign span_end = (span_sum < MEM_END) ? span_sum : MEM_END;

    always_comb begin
        o_flags.lp_full  = (r_lp >= MEM_END);
        o_flags.not_pend = !r_pend;
        o_flags.ra_done  = (r_ra >= r_re);
        o_flags.ra_end1  = ((r_ra + t_addr'(1)) >= r_re);
        o_flags.in_last  = r_lastc;

        priority if (r_halt) begin
            o_flags.scode = SC_HALT;
        end else if (r_pend) begin
            o_flags.scode = SC_PEND;
        end else if (r_ic >= MEM_END) begin
            o_flags.scode = SC_OVR;
        end else begin
            o_flags.scode = SC_GO;
        end

        priority if (c0 == CH_H) begin
            o_flags.cls = CL_H;
        end else if (!known) begin
            o_flags.cls = CL_UNK;
        end else if (!digits) begin
            o_flags.cls = CL_BAD;
        end else if (addr >= MEM_END) begin
            o_flags.cls = CL_OVR;
        end else if (c0 == CH_G) begin
            o_flags.cls = CL_GD;
        end else if (c0 == CH_P) begin
            o_flags.cls = CL_PD;
        end else if (c0 == CH_L) begin
            o_flags.cls = CL_LR;
        end else if (c0 == CH_S) begin
            o_flags.cls = CL_SR;
        end else if (c0 == CH_C) begin
            o_flags.cls = CL_CR;
        end else begin
            o_flags.cls = CL_BT;
        end
    end

    // memory port
    always_comb begin
        o_mreq.we  = i_fire && i_cw.we;
        o_mreq.rd  = i_fire && i_cw.rd;
        o_mreq.clr = i_fire && i_cw.mclr;
        unique case (i_cw.asel)
            A_IC:    o_mreq.addr = r_ic;
            A_ADDR:  o_mreq.addr = addr;
            A_RA:    o_mreq.addr = r_ra;
            A_LP:    o_mreq.addr = r_lp;
            default: o_mreq.addr = r_ic;
        endcase
        unique case (i_cw.wsrc)
            WD_IN:    o_mreq.wdata = r_word;
            WD_ACC:   o_mreq.wdata = r_acc;
            WD_SPACE: o_mreq.wdata = SPACES;
            default:  o_mreq.wdata = SPACES;
        endcase
    end

    always_comb begin
        n_acc  = r_acc;
        n_flag = r_flag;
        n_ic   = r_ic;
        n_lp   = r_lp;
        n_halt = r_halt;
        n_pend = r_pend;
        n_ra   = r_ra;
        n_re   = r_re;
        if (i_fire) begin
            unique case (i_cw.dop)
                D_CLEAR: begin
                    n_acc  = SPACES;
                    n_flag = 1'b0;
                    n_ic   = '0;
                    n_lp   = '0;
                    n_halt = 1'b0;
                    n_pend = 1'b0;
                    n_ra   = '0;
                    n_re   = '0;
                end
                D_LP_INC:   n_lp = r_lp + t_addr'(1);
                D_IC_INC:   n_ic = r_ic + t_addr'(1);
                D_HALT:     n_halt = 1'b1;
                D_GD: begin
                    n_pend = 1'b1;
                    n_ra   = addr;
                    n_re   = span_end;
                end
                D_SPAN: begin
                    n_ra = addr;
                    n_re = span_end;
                end
                D_ACC_LOAD: n_acc = i_rdata;
                D_CMP:      n_flag = (r_acc == i_rdata);
                D_BRANCH: begin
                    if (r_flag) begin
                        n_ic = addr;
                    end
                end
                D_RA_INC:   n_ra = r_ra + t_addr'(1);
                D_PEND_CLR: n_pend = 1'b0;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= SPACES;
            r_flag <= 1'b0;
            r_ic   <= '0;
            r_lp   <= '0;
            r_halt <= 1'b0;
            r_pend <= 1'b0;
            r_ra   <= '0;
            r_re   <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_flag <= n_flag;
            r_ic   <= n_ic;
            r_lp   <= n_lp;
            r_halt <= n_halt;
            r_pend <= n_pend;
            r_ra   <= n_ra;
            r_re   <= n_re;
            if (i_fire && i_cw.emit) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word  <= i_data_word;
            r_lastc <= i_last_of_card;
        end
        if (i_fire && i_cw.dop == D_IR_LOAD) begin
            r_ir <= i_rdata;
        end
        // result carries the machine state as it stands after this step
        if (i_fire && i_cw.emit) begin
            r_ost   <= i_cw.st;
            r_oword <= i_cw.osel ? i_rdata : '0;
            r_olast <= i_cw.lsel ? (r_ra == r_re) : 1'b1;
            r_oic   <= n_ic;
            r_oflag <= n_flag;
        end
    end

    assign o_out_free    = !r_ov || !i_out_stall;
    assign o_out_valid   = r_ov;
    assign o_status      = r_ost;
    assign o_out_word    = r_oword;
    assign o_last        = r_olast;
    assign o_instr_count = r_oic;
    assign o_cond_flag   = r_oflag;

endmodule
